// ----- design/ipd_pkg.sv -----
// Shared constants, types and the arctangent table of the proximity-to-distance pipeline.
package ipd_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int CORDIC_STEPS = 16;

  localparam int DW = 17;   // clamped divisor
  localparam int TW = 38;   // offset angle word before reduction
  localparam int XW = 34;   // CORDIC x and y
  localparam int ZW = 34;   // CORDIC residual angle
  localparam int CW = 17;   // cosine, Q.16
  localparam int NW = 49;   // dividend and quotient
  localparam int QW = 49;   // signed delta product
  localparam int SW = 51;   // root argument before scaling
  localparam int RW = 36;   // radicand
  localparam int ROOTW = RW / 2;
  localparam int REMW = ROOTW + 2;
  localparam int RED_STEPS = 6;

  localparam logic [TW-1:0] PI30 = 38'd3373259426;
  localparam logic [TW-1:0] PI30_X21 = 38'd70838447946;
  localparam logic [TW-1:0] HALF30 = 38'd1686629713;
  localparam logic signed [XW-1:0] GAIN30 = 34'sd652032874;
  localparam logic signed [XW-1:0] ONE30 = 34'sd1073741824;

  localparam logic [2:0] REG_ALPHA = 3'd0;
  localparam logic [2:0] REG_BETA = 3'd1;
  localparam logic [2:0] REG_DELTA = 3'd2;
  localparam logic [2:0] REG_XI = 3'd3;
  localparam logic [2:0] REG_OFS_LOW = 3'd4;
  localparam logic [2:0] REG_OFS_HIGH = 3'd5;

  typedef struct packed {
    logic valid;
    logic clamped;
    logic negative;
  } ctl_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [DW-1:0] d;
  } cord_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [DW-1:0] rem;
    logic [NW-1:0] quot;
    logic [DW-1:0] d;
    logic signed [QW-1:0] q;
  } divs_t;

  typedef struct packed {
    logic [RW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [ROOTW-1:0] root;
  } sqs_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0: a = 30'd843314857;
      5'd1: a = 30'd497837829;
      5'd2: a = 30'd263043837;
      5'd3: a = 30'd133525159;
      5'd4: a = 30'd67021687;
      5'd5: a = 30'd33543516;
      5'd6: a = 30'd16775851;
      5'd7: a = 30'd8388437;
      5'd8: a = 30'd4194283;
      5'd9: a = 30'd2097149;
      5'd10: a = 30'd1048576;
      5'd11: a = 30'd524288;
      5'd12: a = 30'd262144;
      5'd13: a = 30'd131072;
      5'd14: a = 30'd65536;
      5'd15: a = 30'd32768;
      5'd16: a = 30'd16384;
      5'd17: a = 30'd8192;
      5'd18: a = 30'd4096;
      5'd19: a = 30'd2048;
      5'd20: a = 30'd1024;
      5'd21: a = 30'd512;
      5'd22: a = 30'd256;
      5'd23: a = 30'd128;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/ipd_cordic_cell.sv -----
// One CORDIC rotation step with its output register.
module ipd_cordic_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic [4:0]     step,
  input  ipd_pkg::ctl_t  ctl_in,
  input  ipd_pkg::cord_t dat_in,
  output ipd_pkg::ctl_t  ctl_out,
  output ipd_pkg::cord_t dat_out
);

  logic signed [ipd_pkg::XW-1:0] xs;
  logic signed [ipd_pkg::XW-1:0] ys;
  logic signed [ipd_pkg::ZW-1:0] ang;
  ipd_pkg::cord_t dat_next;

  always_comb begin
    xs = $signed(dat_in.x) >>> step;
    ys = $signed(dat_in.y) >>> step;
    ang = $signed({{(ipd_pkg::ZW-30){1'b0}}, ipd_pkg::atan_q30(step)});
    dat_next = dat_in;
    if (!dat_in.z[ipd_pkg::ZW-1]) begin
      dat_next.x = dat_in.x - ys;
      dat_next.y = dat_in.y + xs;
      dat_next.z = dat_in.z - ang;
    end else begin
      dat_next.x = dat_in.x + ys;
      dat_next.y = dat_in.y - xs;
      dat_next.z = dat_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out <= ctl_in;
    end
    dat_out <= dat_next;
  end

endmodule

// ----- design/ipd_div_cell.sv -----
// One quotient bit of the restoring divider with its output register.
module ipd_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  ipd_pkg::ctl_t  ctl_in,
  input  ipd_pkg::divs_t dat_in,
  output ipd_pkg::ctl_t  ctl_out,
  output ipd_pkg::divs_t dat_out
);

  logic [ipd_pkg::DW:0] rem2;
  logic fits;
  ipd_pkg::divs_t dat_next;

  always_comb begin
    rem2 = {dat_in.rem, dat_in.num[ipd_pkg::NW-1]};
    fits = rem2 >= {1'b0, dat_in.d};
    dat_next = dat_in;
    dat_next.num = {dat_in.num[ipd_pkg::NW-2:0], 1'b0};
    dat_next.quot = {dat_in.quot[ipd_pkg::NW-2:0], fits};
    if (fits) begin
      dat_next.rem = ipd_pkg::DW'(rem2 - {1'b0, dat_in.d});
    end else begin
      dat_next.rem = rem2[ipd_pkg::DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out <= ctl_in;
    end
    dat_out <= dat_next;
  end

endmodule

// ----- design/ipd_sqrt_cell.sv -----
// One root bit of the digit-by-digit square root with its output register.
module ipd_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  ipd_pkg::ctl_t ctl_in,
  input  ipd_pkg::sqs_t dat_in,
  output ipd_pkg::ctl_t ctl_out,
  output ipd_pkg::sqs_t dat_out
);

  logic [ipd_pkg::REMW+1:0] rem2;
  logic [ipd_pkg::REMW+1:0] trial;
  logic fits;
  ipd_pkg::sqs_t dat_next;

  always_comb begin
    rem2 = {dat_in.rem, dat_in.rad[ipd_pkg::RW-1:ipd_pkg::RW-2]};
    trial = {2'b00, dat_in.root, 2'b01};
    fits = rem2 >= trial;
    dat_next.rad = {dat_in.rad[ipd_pkg::RW-3:0], 2'b00};
    dat_next.root = {dat_in.root[ipd_pkg::ROOTW-2:0], fits};
    if (fits) begin
      dat_next.rem = ipd_pkg::REMW'(rem2 - trial);
    end else begin
      dat_next.rem = rem2[ipd_pkg::REMW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out <= ctl_in;
    end
    dat_out <= dat_next;
  end

endmodule

// ----- design/ir_proximity_to_distance.sv -----
// Top level: infrared proximity reading to distance, a fully pipelined chain of cells.
//
//   channel   signals                                         direction
//   command   start, busy, reading, angle, sensor_index       in (busy out)
//   result    done, distance, divisor_clamped, argument_negative  out
//   config    write_enable, write_index, write_data           in
//
// One word is taken in every cycle outside reset; each word gives one result word
// after passing the front register, the angle reduction, fold, CORDIC, cosine,
// divider, root argument and square root cells, and the result register, in that order.
// busy is high only during reset. Results are shown for one cycle under done;
// the receiver cannot stall, so nothing ever holds the pipeline.
module ir_proximity_to_distance (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         reading,
  input  logic signed [15:0]  angle,
  input  logic [2:0]          sensor_index,
  output logic                done,
  output logic [15:0]         distance,
  output logic                divisor_clamped,
  output logic                argument_negative,
  input  logic                write_enable,
  input  logic [2:0]          write_index,
  input  logic [63:0]         write_data
);

  localparam int NS = ipd_pkg::CORDIC_STEPS;
  localparam int NR = ipd_pkg::RED_STEPS;
  localparam int ND = ipd_pkg::NW;
  localparam int NQ = ipd_pkg::ROOTW;

  typedef struct packed {
    logic [ipd_pkg::TW-1:0] t;
    logic [ipd_pkg::DW-1:0] d;
  } red_t;

  // configuration registers
  logic [31:0] alpha_gain;
  logic [15:0] beta_bias;
  logic signed [31:0] delta_term;
  logic [15:0] xi_factor;
  logic [63:0] offsets_low_sensors;
  logic [63:0] offsets_high_sensors;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= 32'd65536;
      beta_bias <= 16'd0;
      delta_term <= 32'sd0;
      xi_factor <= 16'd4096;
      offsets_low_sensors <= 64'd0;
      offsets_high_sensors <= 64'd0;
    end else if (write_enable) begin
      case (write_index)
        ipd_pkg::REG_ALPHA: alpha_gain <= write_data[31:0];
        ipd_pkg::REG_BETA: beta_bias <= write_data[15:0];
        ipd_pkg::REG_DELTA: delta_term <= $signed(write_data[31:0]);
        ipd_pkg::REG_XI: xi_factor <= write_data[15:0];
        ipd_pkg::REG_OFS_LOW: offsets_low_sensors <= write_data;
        ipd_pkg::REG_OFS_HIGH: offsets_high_sensors <= write_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // front: divisor and scaled angle product
  logic [15:0] offset;
  logic signed [17:0] diff;
  logic signed [32:0] prod;
  ipd_pkg::ctl_t s1_ctl;
  logic signed [32:0] s1_prod;
  logic [ipd_pkg::DW-1:0] s1_d;

  always_comb begin
    offset = 16'd0;
    if (32'(sensor_index) < ipd_pkg::SENSOR_COUNT) begin
      if (!sensor_index[2]) begin
        offset = offsets_low_sensors[16*sensor_index[1:0] +: 16];
      end else begin
        offset = offsets_high_sensors[16*sensor_index[1:0] +: 16];
      end
    end
    diff = $signed({2'b00, reading}) - $signed({{2{offset[15]}}, offset})
         - $signed({2'b00, beta_bias});
    prod = $signed({1'b0, xi_factor}) * angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= start;
      s1_ctl.clamped <= diff <= 18'sd0;
      s1_ctl.negative <= 1'b0;
    end
    s1_prod <= prod;
    s1_d <= (diff <= 18'sd0) ? ipd_pkg::DW'(1) : diff[ipd_pkg::DW-1:0];
  end

  // offset the angle so that it is never negative, then reduce it modulo pi
  ipd_pkg::ctl_t red_ctl [0:NR];
  red_t red_dat [0:NR];
  logic signed [ipd_pkg::TW:0] t_wide;

  assign t_wide = ($signed({{(ipd_pkg::TW-32){s1_prod[32]}}, s1_prod}) <<< 5)
                + $signed({1'b0, ipd_pkg::PI30_X21});

  always_ff @(posedge clk) begin
    if (rst) begin
      red_ctl[0].valid <= 1'b0;
    end else begin
      red_ctl[0] <= s1_ctl;
    end
    red_dat[0].t <= t_wide[ipd_pkg::TW-1:0];
    red_dat[0].d <= s1_d;
  end

  for (genvar k = 0; k < NR; k++) begin : g_red
    localparam logic [ipd_pkg::TW-1:0] M = ipd_pkg::PI30 << (NR - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        red_ctl[k+1].valid <= 1'b0;
      end else begin
        red_ctl[k+1] <= red_ctl[k];
      end
      red_dat[k+1].d <= red_dat[k].d;
      red_dat[k+1].t <= (red_dat[k].t >= M) ? red_dat[k].t - M : red_dat[k].t;
    end
  end

  // fold into [-pi/2, pi/2] and start the rotation
  ipd_pkg::ctl_t cord_ctl [0:NS];
  ipd_pkg::cord_t cord_dat [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cord_ctl[0].valid <= 1'b0;
    end else begin
      cord_ctl[0] <= red_ctl[NR];
    end
    cord_dat[0].x <= ipd_pkg::GAIN30;
    cord_dat[0].y <= '0;
    cord_dat[0].d <= red_dat[NR].d;
    if (red_dat[NR].t > ipd_pkg::HALF30) begin
      cord_dat[0].z <= $signed(ipd_pkg::ZW'(red_dat[NR].t - ipd_pkg::PI30));
    end else begin
      cord_dat[0].z <= $signed(ipd_pkg::ZW'(red_dat[NR].t));
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    ipd_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .step    (5'(i)),
      .ctl_in  (cord_ctl[i]),
      .dat_in  (cord_dat[i]),
      .ctl_out (cord_ctl[i+1]),
      .dat_out (cord_dat[i+1])
    );
  end

  // cosine magnitude in Q.16
  logic signed [ipd_pkg::XW-1:0] x_cl;
  logic [ipd_pkg::XW-1:0] x_rnd;
  ipd_pkg::ctl_t c_ctl;
  logic [ipd_pkg::CW-1:0] c_val;
  logic [ipd_pkg::DW-1:0] c_d;

  always_comb begin
    x_cl = cord_dat[NS].x;
    if (x_cl < 0) begin
      x_cl = '0;
    end else if (x_cl > ipd_pkg::ONE30) begin
      x_cl = ipd_pkg::ONE30;
    end
    x_rnd = ($unsigned(x_cl) + ipd_pkg::XW'(8192)) >> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl.valid <= 1'b0;
    end else begin
      c_ctl <= cord_ctl[NS];
    end
    c_val <= (x_rnd > ipd_pkg::XW'(65536)) ? ipd_pkg::CW'(65536) : x_rnd[ipd_pkg::CW-1:0];
    c_d <= cord_dat[NS].d;
  end

  // gain and additive products
  ipd_pkg::ctl_t div_ctl [0:ND];
  ipd_pkg::divs_t div_dat [0:ND];
  logic [48:0] n_prod;
  logic signed [49:0] q_prod;

  always_comb begin
    n_prod = alpha_gain * c_val;
    q_prod = delta_term * $signed({1'b0, c_val});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_ctl[0].valid <= 1'b0;
    end else begin
      div_ctl[0] <= c_ctl;
    end
    div_dat[0].num <= n_prod[ipd_pkg::NW-1:0];
    div_dat[0].rem <= '0;
    div_dat[0].quot <= '0;
    div_dat[0].d <= c_d;
    div_dat[0].q <= q_prod[ipd_pkg::QW-1:0];
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    ipd_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (div_ctl[j]),
      .dat_in  (div_dat[j]),
      .ctl_out (div_ctl[j+1]),
      .dat_out (div_dat[j+1])
    );
  end

  // root argument and its sign
  ipd_pkg::ctl_t sq_ctl [0:NQ];
  ipd_pkg::sqs_t sq_dat [0:NQ];
  logic signed [ipd_pkg::SW-1:0] s_sum;

  assign s_sum = $signed({2'b00, div_dat[ND].quot})
               + $signed({{(ipd_pkg::SW-ipd_pkg::QW){div_dat[ND].q[ipd_pkg::QW-1]}},
                          div_dat[ND].q});

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ctl[0].valid <= 1'b0;
    end else begin
      sq_ctl[0].valid <= div_ctl[ND].valid;
      sq_ctl[0].clamped <= div_ctl[ND].clamped;
      sq_ctl[0].negative <= s_sum[ipd_pkg::SW-1];
    end
    sq_dat[0].rad <= ipd_pkg::RW'(s_sum[ipd_pkg::SW-2:16]);
    sq_dat[0].rem <= '0;
    sq_dat[0].root <= '0;
  end

  for (genvar r = 0; r < NQ; r++) begin : g_sqrt
    ipd_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (sq_ctl[r]),
      .dat_in  (sq_dat[r]),
      .ctl_out (sq_ctl[r+1]),
      .dat_out (sq_dat[r+1])
    );
  end

  // result word, saturated
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_ctl[NQ].valid;
    end
    divisor_clamped <= sq_ctl[NQ].clamped;
    argument_negative <= sq_ctl[NQ].negative;
    if (sq_ctl[NQ].negative) begin
      distance <= 16'd0;
    end else if (|sq_dat[NQ].root[ipd_pkg::ROOTW-1:16]) begin
      distance <= 16'hFFFF;
    end else begin
      distance <= sq_dat[NQ].root[15:0];
    end
  end

endmodule

// ----- dv/tb_ir_proximity_to_distance.sv -----
// Self-checking testbench of the infrared proximity-to-distance pipeline.
`timescale 1ns / 100ps

module tb_ir_proximity_to_distance;

  typedef struct {
    logic [15:0] reading;
    logic signed [15:0] angle;
    logic [2:0] sensor_index;
    int unsigned gap;
  } reading_word_t;

  typedef struct {
    logic [15:0] distance;
    logic clamped;
    logic negative;
  } distance_word_t;

  localparam int PIPE_LATENCY = 96;
  // An index that names no register; a write to it must change nothing.
  localparam logic [2:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] reading = '0;
  logic signed [15:0] angle = '0;
  logic [2:0] sensor_index = '0;
  logic done;
  logic [15:0] distance;
  logic divisor_clamped;
  logic argument_negative;
  logic write_enable = 1'b0;
  logic [2:0] write_index = '0;
  logic [63:0] write_data = '0;

  // Mirror of the configuration registers.
  logic [31:0] alpha_q;
  logic [15:0] beta_q;
  logic signed [31:0] delta_q;
  logic [15:0] xi_q;
  logic [63:0] ofs_low_q;
  logic [63:0] ofs_high_q;

  reading_word_t pending_words[$];
  distance_word_t expected_distances[$];
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned clamped_seen = 0;
  int unsigned negative_seen = 0;
  bit feeding_done = 1'b0;
  int unsigned gap_left = 0;

  ir_proximity_to_distance dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .reading(reading), .angle(angle), .sensor_index(sensor_index),
    .done(done), .distance(distance), .divisor_clamped(divisor_clamped),
    .argument_negative(argument_negative), .write_enable(write_enable),
    .write_index(write_index), .write_data(write_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] settle_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint abs_cosine_q16(input longint theta);
    longint z;
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint c;
    z = theta % longint'(ipd_pkg::PI30);
    x = longint'(ipd_pkg::GAIN30);
    y = 0;
    if (z < 0) z += longint'(ipd_pkg::PI30);
    if (z > longint'(ipd_pkg::HALF30)) z -= longint'(ipd_pkg::PI30);
    for (int i = 0; i < ipd_pkg::CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ipd_pkg::atan_q30(i[4:0]));
      end else begin
        x += ys; y -= xs; z += longint'(ipd_pkg::atan_q30(i[4:0]));
      end
    end
    if (x < 0) x = 0;
    if (x > longint'(ipd_pkg::ONE30)) x = longint'(ipd_pkg::ONE30);
    c = (x + 8192) >>> 14;
    if (c > 65536) c = 65536;
    return c;
  endfunction

  function automatic distance_word_t predict_distance(input reading_word_t w);
    distance_word_t r;
    longint ofs;
    longint d;
    longint c;
    longint q;
    longint s;
    logic [63:0] p;
    logic [63:0] root;
    ofs = 0;
    if (w.sensor_index < ipd_pkg::SENSOR_COUNT) begin
      if (w.sensor_index < 4)
        ofs = longint'($signed(ofs_low_q[16*w.sensor_index +: 16]));
      else
        ofs = longint'($signed(ofs_high_q[16*(w.sensor_index-4) +: 16]));
    end
    d = longint'(w.reading) - ofs - longint'(beta_q);
    r.clamped = 1'b0;
    if (d <= 0) begin
      d = 1;
      r.clamped = 1'b1;
    end
    c = abs_cosine_q16(longint'(xi_q) * longint'(w.angle) * 32);
    p = (64'(alpha_q) * 64'(c)) / 64'(d);
    q = longint'(delta_q) * c;
    s = longint'(p) + q;
    r.negative = 1'b0;
    if (s < 0) begin
      r.distance = '0;
      r.negative = 1'b1;
    end else begin
      root = settle_sqrt(64'(s) >> 16);
      r.distance = (root > 65535) ? 16'hFFFF : root[15:0];
    end
    return r;
  endfunction

  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      ipd_pkg::REG_ALPHA: alpha_q = value[31:0];
      ipd_pkg::REG_BETA: beta_q = value[15:0];
      ipd_pkg::REG_DELTA: delta_q = value[31:0];
      ipd_pkg::REG_XI: xi_q = value[15:0];
      ipd_pkg::REG_OFS_LOW: ofs_low_q = value;
      ipd_pkg::REG_OFS_HIGH: ofs_high_q = value;
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [15:0] rd, input logic [15:0] an, input logic [2:0] si,
                            input bit with_gap);
    reading_word_t w;
    w.reading = rd;
    w.angle = an;
    w.sensor_index = si;
    w.gap = 0;
    if (with_gap && $urandom_range(3) != 0) w.gap = $urandom_range(13);
    pending_words.push_back(w);
  endtask

  // Waits until the pipeline has drained, so a register write hits an idle block.
  task automatic drain_pipeline();
    while (pending_words.size() != 0 || start || expected_distances.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_words(input int n);
    logic [15:0] rd;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: rd = 16'($urandom);
        1: rd = 16'($urandom_range(300));
        2: rd = 16'(16'hFFFF - $urandom_range(300));
        default: rd = 16'(beta_q + $urandom_range(40));
      endcase
      queue_word(rd, 16'($urandom), 3'($urandom), k % 100 < 70);
    end
  endtask

  // Driver: a word is taken at an edge with start high and busy low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_words.size() != 0 && !(start && !busy && pending_words[0].gap != 0)) begin
      reading_word_t w;
      w = pending_words.pop_front();
      start <= 1'b1;
      reading <= w.reading;
      angle <= w.angle;
      sensor_index <= w.sensor_index;
      expected_distances.push_back(predict_distance(w));
      if (pending_words.size() != 0) gap_left <= pending_words[0].gap;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every done cycle carries one result word.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: distance %0d", distance);
      end else begin
        distance_word_t e;
        e = expected_distances.pop_front();
        words_checked++;
        clamped_seen += e.clamped;
        negative_seen += e.negative;
        if (e.distance !== distance || e.clamped !== divisor_clamped ||
            e.negative !== argument_negative) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected dist %0d clamp %0b neg %0b, got %0d %0b %0b",
                     e.distance, e.clamped, e.negative,
                     distance, divisor_clamped, argument_negative);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    alpha_q = 32'd65536;
    beta_q = '0;
    delta_q = '0;
    xi_q = 16'd4096;
    ofs_low_q = '0;
    ofs_high_q = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset settings: field extremes, zero and right angles.
    queue_word(16'd0, 16'sd0, 3'd0, 1'b0);
    queue_word(16'hFFFF, 16'sd0, 3'd7, 1'b0);
    queue_word(16'd1, 16'sh7FFF, 3'd1, 1'b0);
    queue_word(16'd1000, -16'sd32768, 3'd2, 1'b1);
    queue_word(16'd2, 16'sd12868, 3'd3, 1'b0);
    queue_word(16'd500, -16'sd12868, 3'd4, 1'b0);
    queue_word(16'h5555, 16'sh5555, 3'd5, 1'b1);
    queue_word(16'hAAAA, 16'shAAAA, 3'd6, 1'b0);
    drain_pipeline();

    // Offsets, bias and a negative delta: clamped divisors and negative roots.
    write_register(ipd_pkg::REG_OFS_LOW, 64'h8000_7FFF_FFFF_0001);
    write_register(ipd_pkg::REG_OFS_HIGH, 64'h0100_FF00_0000_7FFF);
    write_register(ipd_pkg::REG_BETA, 16'd100);
    write_register(ipd_pkg::REG_DELTA, 32'hFFFF_0000);
    write_register(ipd_pkg::REG_ALPHA, 32'd10);
    write_register(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int s = 0; s < 8; s++) queue_word(16'd50 + 16'(s), 16'sd0, 3'(s), 1'b1);
    queue_word(16'hFFFF, 16'sd100, 3'd0, 1'b0);
    drain_pipeline();

    // Extreme gain and delta, largest angle scale: saturation and wrap of the angle.
    write_register(ipd_pkg::REG_ALPHA, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(ipd_pkg::REG_DELTA, 32'h7FFF_FFFF);
    write_register(ipd_pkg::REG_XI, 16'hFFFF);
    write_register(ipd_pkg::REG_BETA, 16'hFFFF);
    queue_word(16'd0, 16'sh7FFF, 3'd0, 1'b0);
    queue_word(16'hFFFF, -16'sd32768, 3'd7, 1'b0);
    random_words(150);
    drain_pipeline();

    for (int ph = 0; ph < 4; ph++) begin
      write_register(ipd_pkg::REG_ALPHA, $urandom);
      write_register(ipd_pkg::REG_BETA, $urandom_range(2000));
      write_register(ipd_pkg::REG_DELTA,
                     (ph == 1) ? 32'h8000_0000 : $signed($urandom_range(4000)) - 1000);
      write_register(ipd_pkg::REG_XI, (ph == 2) ? 16'd0 : 16'($urandom));
      write_register(ipd_pkg::REG_OFS_LOW, {$urandom, $urandom});
      write_register(ipd_pkg::REG_OFS_HIGH, {$urandom, $urandom});
      random_words(120);
      drain_pipeline();
    end

    $display("Checked %0d result words over seven register settings;", words_checked);
    $display("%0d had a clamped divisor, %0d a negative root argument.",
             clamped_seen, negative_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ipd_pkg.sv
design/ipd_cordic_cell.sv
design/ipd_div_cell.sv
design/ipd_sqrt_cell.sv
design/ir_proximity_to_distance.sv
dv/tb_ir_proximity_to_distance.sv
